// ----- design/cnv_pkg.sv -----
// shared types, constants and codes of the 7x7 image filter
package cnv_pkg;

    localparam int KS        = 7;
    localparam int PAD       = 3;
    localparam int KK        = KS * KS;
    localparam int FRAC      = 11;
    localparam int MAX_W     = 1024;
    localparam int ROW_LIMIT = 1024;
    localparam int AW        = 10;
    localparam int LB_ROWS   = KS - 1;
    localparam int LB_W      = LB_ROWS * 8;
    localparam int PROD_W    = 25;
    localparam int ROW_W     = 28;
    localparam int ACC_W     = 31;
    localparam int FIFO_D    = 16;
    localparam int FIFO_AW   = 4;
    localparam int CRED_W    = 5;
    // one item issues at most PAD+1 results, plus one from the item ahead of it
    localparam int CRED_OK   = FIFO_D - PAD - 2;

    localparam logic [1:0] MODE_COEF   = 2'd0;
    localparam logic [1:0] MODE_PIXEL  = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [0:0] REG_WIDTH  = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         pixel;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
    } t_in;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic       run_last;
        logic       frame_end;
    } t_out;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
        logic       fend;
    } t_tag;

    typedef logic [7:0] t_win [KS][KS];
    typedef logic signed [15:0] t_coefs [KK];

endpackage

// ----- design/cnv_lb_ram.sv -----
// line buffer memory: one word per column holds the six buffered rows
module cnv_lb_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [cnv_pkg::AW-1:0]    i_waddr,
    input  logic [cnv_pkg::LB_W-1:0]  i_wdata,
    input  logic [cnv_pkg::AW-1:0]    i_raddr,
    output logic [cnv_pkg::LB_W-1:0]  o_rdata
);

    logic [cnv_pkg::LB_W-1:0] r_mem [cnv_pkg::MAX_W];
    logic [cnv_pkg::LB_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cnv_mac.sv -----
// 49-tap multiply, registered adder tree, shift and clamp
module cnv_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cnv_pkg::t_win   i_win,
    input  cnv_pkg::t_coefs i_coef,
    input  logic            i_valid,
    input  cnv_pkg::t_tag   i_tag,
    output logic            o_valid,
    output cnv_pkg::t_out   o_data
);

    logic signed [cnv_pkg::PROD_W-1:0] r_prod [cnv_pkg::KS][cnv_pkg::KS];
    logic signed [cnv_pkg::ROW_W-1:0]  n_rsum [cnv_pkg::KS];
    logic signed [cnv_pkg::ROW_W-1:0]  r_rsum [cnv_pkg::KS];
    logic signed [cnv_pkg::ACC_W-1:0]  n_acc;
    logic signed [cnv_pkg::ACC_W-1:0]  r_acc;
    logic                              r_v1, r_v2, r_v3;
    cnv_pkg::t_tag                     r_t1, r_t2, r_t3;
    logic [7:0]                        pix;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cnv_pkg::KS; k++) begin
            for (int p = 0; p < cnv_pkg::KS; p++) begin
                r_prod[k][p] <= cnv_pkg::PROD_W'($signed({1'b0, i_win[k][p]})) *
                                cnv_pkg::PROD_W'(i_coef[k*cnv_pkg::KS+p]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < cnv_pkg::KS; k++) begin
            n_rsum[k] = '0;
            for (int p = 0; p < cnv_pkg::KS; p++) begin
                n_rsum[k] = n_rsum[k] + cnv_pkg::ROW_W'(r_prod[k][p]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsum <= n_rsum;
    end

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < cnv_pkg::KS; k++) begin
            n_acc = n_acc + cnv_pkg::ACC_W'(r_rsum[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_t1  <= i_tag;
        r_t2  <= r_t1;
        r_t3  <= r_t2;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // non-positive sums give zero, so the shift never sees a negative value
    always_comb begin
        if (r_acc <= 0) begin
            pix = 8'd0;
        end else if (r_acc[cnv_pkg::ACC_W-1:cnv_pkg::FRAC] > 20'd255) begin
            pix = 8'd255;
        end else begin
            pix = r_acc[cnv_pkg::FRAC+7:cnv_pkg::FRAC];
        end
    end

    assign o_valid          = r_v3;
    assign o_data.out_pixel = pix;
    assign o_data.out_row   = r_t3.row;
    assign o_data.out_col   = r_t3.col;
    assign o_data.run_last  = r_t3.last;
    assign o_data.frame_end = r_t3.fend;

endmodule

// ----- design/cnv_ofifo.sv -----
// output queue between the filter pipeline and the result channel
module cnv_ofifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cnv_pkg::t_out i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output cnv_pkg::t_out o_data
);

    cnv_pkg::t_out                  r_mem [cnv_pkg::FIFO_D];
    logic [cnv_pkg::FIFO_AW-1:0]    r_wptr;
    logic [cnv_pkg::FIFO_AW-1:0]    r_rptr;
    logic [cnv_pkg::CRED_W-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + cnv_pkg::CRED_W'(i_push) - cnv_pkg::CRED_W'(i_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

// ----- design/image_filter_7x7_zero_padded.sv -----
// top level of the streaming 7x7 zero-padded image filter
//
// Input channel (i_valid / o_stall, payload i_data) carries coefficient loads,
// raster-order pixels and flush items; a transfer happens when i_valid is high
// and o_stall is low. Results leave on o_valid / i_stall with o_data.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 image
// width, 1 image height); the user must write it only while the block is
// idle; the block does not enforce it. Throughput: one item per cycle inside
// a row while o_stall is low; the item that ends a row holds o_stall high
// while the window shifts three zero columns through the single multiply-add
// tree to finish the right edge of the row. A result passes the line buffer
// read, window update, products, row sums and total registers and the result
// queue before it reaches o_valid. The line buffers sit in one 1024-word
// memory, read and written back once per pixel; two uses of the same column
// are at least four items apart. Reset: a clearing pass writes zeros over all
// 1024 words with o_stall high; coefficients, window and counters reset to
// zero. A stalled receiver fills a 16-entry result queue; intake stops while
// the queue cannot hold the results of one more item.
module image_filter_7x7_zero_padded (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cnv_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output cnv_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [10:0]   i_cfg_data
);

    // configuration and scan state
    logic [10:0]               r_cfg_w, r_cfg_h;
    logic [10:0]               w_use, h_use;
    logic [10:0]               r_row;
    logic [cnv_pkg::AW-1:0]    r_col;

    // clearing pass
    logic                      r_clr_busy;
    logic [cnv_pkg::AW-1:0]    r_clr_addr;

    // accept stage
    logic                      acc, pix_item, coef_item, rowend, frame_done;
    logic [7:0]                v;

    // window stage
    logic                      r_b_valid, r_b_c0, r_b_emit, r_b_rowend, r_b_tail_emit;
    logic                      r_b_fd;
    logic [7:0]                r_b_v;
    logic [cnv_pkg::AW-1:0]    r_b_addr;
    logic [9:0]                r_b_row, r_b_col;
    logic                      r_b_cwe;
    logic [5:0]                r_b_cidx;
    logic signed [15:0]        r_b_cval;

    logic [1:0]                r_tail;
    logic [9:0]                r_tail_row, r_tail_col;
    logic                      r_tail_emit, r_tail_fd;

    cnv_pkg::t_win             r_win;
    cnv_pkg::t_coefs           r_coef;
    logic [7:0]                column [cnv_pkg::KS];

    logic [cnv_pkg::LB_W-1:0]  rdata, wdata;
    logic                      mem_we;
    logic [cnv_pkg::AW-1:0]    mem_waddr;

    logic                      n_iss;
    cnv_pkg::t_tag             n_tag;
    logic                      r_iss;
    cnv_pkg::t_tag             r_tag;
    logic [cnv_pkg::CRED_W-1:0] r_credit;

    logic                      mac_valid;
    cnv_pkg::t_out             mac_data;
    logic                      pop;

    always_comb begin
        if (r_cfg_w < 11'(cnv_pkg::PAD + 1)) begin
            w_use = 11'(cnv_pkg::PAD + 1);
        end else if (r_cfg_w > 11'(cnv_pkg::MAX_W)) begin
            w_use = 11'(cnv_pkg::MAX_W);
        end else begin
            w_use = r_cfg_w;
        end
        if (r_cfg_h < 11'(cnv_pkg::PAD + 1)) begin
            h_use = 11'(cnv_pkg::PAD + 1);
        end else if (r_cfg_h > 11'(cnv_pkg::ROW_LIMIT)) begin
            h_use = 11'(cnv_pkg::ROW_LIMIT);
        end else begin
            h_use = r_cfg_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 11'(cnv_pkg::MAX_W);
            r_cfg_h <= 11'(cnv_pkg::ROW_LIMIT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cnv_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data;
                cnv_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = r_clr_busy || (r_b_valid && r_b_rowend) || (r_tail > 2'd1) ||
                     (r_credit > cnv_pkg::CRED_W'(cnv_pkg::CRED_OK));
    assign acc       = i_valid && !o_stall;
    assign pix_item  = acc && (i_data.mode == cnv_pkg::MODE_PIXEL ||
                               i_data.mode == cnv_pkg::MODE_FLUSH);
    assign coef_item = acc && (i_data.mode == cnv_pkg::MODE_COEF) &&
                       (i_data.coef_index < 6'(cnv_pkg::KK));
    assign v          = (i_data.mode == cnv_pkg::MODE_PIXEL && r_row < h_use) ?
                        i_data.pixel : 8'd0;
    assign rowend     = ({1'b0, r_col} + 11'd1) >= w_use;
    assign frame_done = ({1'b0, r_row} + 12'd1) >= ({1'b0, h_use} + 12'(cnv_pkg::PAD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (pix_item) begin
            if (rowend) begin
                r_col <= '0;
                r_row <= frame_done ? 11'd0 : r_row + 11'd1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == cnv_pkg::AW'(cnv_pkg::MAX_W - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // accept stage to window stage
    always_ff @(posedge i_clk) begin
        r_b_v         <= v;
        r_b_addr      <= r_col;
        r_b_c0        <= (r_col == '0);
        r_b_emit      <= (r_row >= 11'(cnv_pkg::PAD)) && (r_col >= cnv_pkg::AW'(cnv_pkg::PAD));
        r_b_tail_emit <= (r_row >= 11'(cnv_pkg::PAD));
        r_b_rowend    <= rowend;
        r_b_fd        <= rowend && frame_done;
        r_b_row       <= 10'(r_row - 11'(cnv_pkg::PAD));
        r_b_col       <= r_col - 10'(cnv_pkg::PAD);
        r_b_cidx      <= i_data.coef_index;
        r_b_cval      <= i_data.coef_value;
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_cwe   <= 1'b0;
        end else begin
            r_b_valid <= pix_item;
            r_b_cwe   <= coef_item;
        end
    end

    // coefficients change one stage late, after earlier windows took their products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cnv_pkg::KK; i++) begin
                r_coef[i] <= '0;
            end
        end else if (r_b_cwe) begin
            r_coef[r_b_cidx] <= r_b_cval;
        end
    end

    always_comb begin
        for (int k = 0; k < cnv_pkg::LB_ROWS; k++) begin
            column[k] = rdata[8*k +: 8];
        end
        column[cnv_pkg::KS-1] = r_b_v;
        for (int k = 0; k < cnv_pkg::LB_ROWS - 1; k++) begin
            wdata[8*k +: 8] = column[k+1];
        end
        wdata[8*(cnv_pkg::LB_ROWS-1) +: 8] = r_b_v;
    end

    assign mem_we    = r_clr_busy || r_b_valid;
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_b_addr;

    cnv_lb_ram u_lb (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_clr_busy ? '0 : wdata),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    // window shift: new column on a pixel, zero columns during the row tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cnv_pkg::KS; k++) begin
                for (int p = 0; p < cnv_pkg::KS; p++) begin
                    r_win[k][p] <= '0;
                end
            end
        end else if (r_b_valid) begin
            for (int k = 0; k < cnv_pkg::KS; k++) begin
                for (int p = 0; p < cnv_pkg::KS - 1; p++) begin
                    r_win[k][p] <= r_b_c0 ? 8'd0 : r_win[k][p+1];
                end
                r_win[k][cnv_pkg::KS-1] <= column[k];
            end
        end else if (r_tail != 2'd0) begin
            for (int k = 0; k < cnv_pkg::KS; k++) begin
                for (int p = 0; p < cnv_pkg::KS - 1; p++) begin
                    r_win[k][p] <= r_win[k][p+1];
                end
                r_win[k][cnv_pkg::KS-1] <= 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 2'd0;
        end else if (r_b_valid && r_b_rowend) begin
            r_tail <= 2'(cnv_pkg::PAD);
        end else if (r_tail != 2'd0) begin
            r_tail <= r_tail - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_rowend) begin
            r_tail_row  <= r_b_row;
            r_tail_col  <= r_b_col;
            r_tail_emit <= r_b_tail_emit;
            r_tail_fd   <= r_b_fd;
        end else if (r_tail != 2'd0) begin
            r_tail_col  <= r_tail_col + 10'd1;
        end
    end

    always_comb begin
        n_iss = 1'b0;
        n_tag = '0;
        if (r_b_valid) begin
            n_iss    = r_b_emit;
            n_tag.row  = r_b_row;
            n_tag.col  = r_b_col;
            n_tag.last = !r_b_rowend;
        end else if (r_tail != 2'd0) begin
            n_iss      = r_tail_emit;
            n_tag.row  = r_tail_row;
            n_tag.col  = r_tail_col + 10'd1;
            n_tag.last = (r_tail == 2'd1);
            n_tag.fend = (r_tail == 2'd1) && r_tail_fd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        if (!i_rst_n) begin
            r_iss    <= 1'b0;
            r_credit <= '0;
        end else begin
            r_iss    <= n_iss;
            r_credit <= r_credit + cnv_pkg::CRED_W'(n_iss) - cnv_pkg::CRED_W'(pop);
        end
    end

    cnv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_coef  (r_coef),
        .i_valid (r_iss),
        .i_tag   (r_tag),
        .o_valid (mac_valid),
        .o_data  (mac_data)
    );

    assign pop = o_valid && !i_stall;

    cnv_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mac_valid),
        .i_data  (mac_data),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= cnv_pkg::CRED_W'(cnv_pkg::FIFO_D))
        else $error("result queue over-committed");

    a_no_transfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_stall)
        else $error("input transfer during clearing pass");

    a_tail_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_b_valid && (r_tail != 2'd0)))
        else $error("pixel reached window during row tail");

    a_tail_follows_rowend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_rowend) |=> (r_tail == 2'(cnv_pkg::PAD)))
        else $error("row tail did not start");

endmodule

// ----- tb/image_filter_7x7_zero_padded_tb.sv -----
// testbench of the 7x7 zero-padded image filter: random frames checked against a predictor
`timescale 1ns / 100ps

class filt_scoreboard;
    logic signed [15:0] coefs [49];
    logic [7:0]  lines [6][1024];
    logic [7:0]  win [7][7];
    int unsigned row_pos, col_pos, width_reg, height_reg;
    cnv_pkg::t_out pending[$];
    int n_bad, n_seen;

    function void reset_state();
        foreach (coefs[i]) coefs[i] = '0;
        foreach (lines[k, c]) lines[k][c] = '0;
        foreach (win[k, p]) win[k][p] = '0;
        row_pos = 0;
        col_pos = 0;
        width_reg = 1024;
        height_reg = 1024;
        n_bad = 0;
        n_seen = 0;
    endfunction

    function void shift_in(logic [7:0] colv [7]);
        for (int k = 0; k < 7; k++) begin
            for (int p = 0; p < 6; p++) win[k][p] = win[k][p + 1];
            win[k][6] = colv[k];
        end
    endfunction

    function logic [7:0] filtered();
        longint acc;
        acc = 0;
        for (int k = 0; k < 7; k++)
            for (int p = 0; p < 7; p++)
                acc += longint'(coefs[k * 7 + p]) * longint'({1'b0, win[k][p]});
        if (acc <= 0) return 8'd0;
        acc = acc >>> 11;
        if (acc > 255) return 8'd255;
        return acc[7:0];
    endfunction

    function void push_out(int unsigned r, int unsigned c);
        cnv_pkg::t_out o;
        o.out_pixel = filtered();
        o.out_row = r[9:0];
        o.out_col = c[9:0];
        o.run_last = 1'b0;
        o.frame_end = 1'b0;
        pending.push_back(o);
    endfunction

    // note an accepted input transfer and queue its expected results
    function void note_input(cnv_pkg::t_in d);
        int unsigned w, h, r, c, n;
        logic [7:0] v;
        logic [7:0] colv [7];
        bit done;
        w = width_reg < 4 ? 4 : (width_reg > 1024 ? 1024 : width_reg);
        h = height_reg < 4 ? 4 : (height_reg > 1024 ? 1024 : height_reg);
        r = row_pos;
        c = col_pos;
        n = 0;
        done = 0;
        if (d.mode == cnv_pkg::MODE_UNUSED) return;
        if (d.mode == cnv_pkg::MODE_COEF) begin
            if (d.coef_index < 49) coefs[d.coef_index] = d.coef_value;
            return;
        end
        v = (d.mode == cnv_pkg::MODE_PIXEL && r < h) ? d.pixel : 8'd0;
        if (c >= 1024) c = 1023;
        if (c == 0) foreach (win[k, p]) win[k][p] = '0;
        for (int k = 0; k < 6; k++) colv[k] = lines[k][c];
        colv[6] = v;
        for (int k = 0; k < 5; k++) lines[k][c] = colv[k + 1];
        lines[5][c] = v;
        shift_in(colv);
        if (r >= 3 && c >= 3) begin
            push_out(r - 3, c - 3);
            n++;
        end
        if (c + 1 >= w) begin
            foreach (colv[k]) colv[k] = '0;
            for (int t = 1; t <= 3; t++) begin
                shift_in(colv);
                if (r >= 3) begin
                    push_out(r - 3, c - 3 + t);
                    n++;
                end
            end
            col_pos = 0;
            if (r + 1 >= h + 3) begin
                row_pos = 0;
                done = 1;
            end else row_pos = r + 1;
        end else col_pos = c + 1;
        if (n > 0) begin
            pending[$].run_last = 1'b1;
            if (done) pending[$].frame_end = 1'b1;
        end
    endfunction

    function void check_result(cnv_pkg::t_out got);
        cnv_pkg::t_out exp_o;
        n_seen++;
        if (pending.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_o = pending.pop_front();
        if (got !== exp_o) begin
            n_bad++;
            if (n_bad <= 10) $display("mismatch: expected %p, actual %p", exp_o, got);
        end
    endfunction
endclass

module image_filter_7x7_zero_padded_tb;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, i_cfg_we;
    cnv_pkg::t_in i_data;
    cnv_pkg::t_out o_data;
    logic [0:0] i_cfg_index;
    logic [10:0] i_cfg_data;
    filt_scoreboard sb;
    bit calm, hold_rx;
    int unsigned cycles, n_frames;

    image_filter_7x7_zero_padded i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);

    // receiver stall: random bursts, a long hold when asked, none when calm
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                hold_rx = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // valid stays high between back-to-back transfers; callers drop it when done
    task automatic send(cnv_pkg::t_in d);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_data <= d;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(d);
    endtask

    task automatic send_coef(int idx, logic signed [15:0] val);
        cnv_pkg::t_in d;
        d = '{mode: cnv_pkg::MODE_COEF, pixel: 8'($urandom), coef_index: idx[5:0],
              coef_value: val};
        send(d);
    endtask

    task automatic send_px(logic [1:0] mode, logic [7:0] px);
        cnv_pkg::t_in d;
        d = '{mode: mode, pixel: px, coef_index: 6'($urandom), coef_value: 16'($urandom)};
        send(d);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [10:0] val);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cnv_pkg::REG_WIDTH) sb.width_reg = val;
        else sb.height_reg = val;
        @(posedge i_clk);
    endtask

    // one whole frame: pixels with random mix of flushes, then flush rows
    task automatic run_frame(int w, int h, int extreme);
        logic [7:0] px;
        for (int i = 0; i < (h + 3) * w; i++) begin
            if (i < h * w) begin
                px = extreme == 1 ? 8'hFF : (extreme == 2 ? 8'h00 : 8'($urandom));
                send_px($urandom_range(0, 15) == 0 ? cnv_pkg::MODE_FLUSH :
                        cnv_pkg::MODE_PIXEL, px);
            end else send_px($urandom_range(0, 5) == 0 ? cnv_pkg::MODE_PIXEL :
                             cnv_pkg::MODE_FLUSH, 8'($urandom));
            if ($urandom_range(0, 30) == 0) send_px(cnv_pkg::MODE_UNUSED, 8'($urandom));
        end
        n_frames++;
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_data = '0;
        calm = 0;
        hold_rx = 0;
        cycles = 0;
        n_frames = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: register clamping, extreme coefficients, ignored index, unused mode
        write_reg(cnv_pkg::REG_WIDTH, 11'd0);
        write_reg(cnv_pkg::REG_HEIGHT, 11'd2047);
        write_reg(cnv_pkg::REG_HEIGHT, 11'd4);
        send_coef(24, 16'sd2048);
        send_coef(0, 16'sh7FFF);
        send_coef(48, 16'sh8000);
        send_coef(63, 16'sh7FFF);
        send_coef(49, 16'sh1234);
        send_px(cnv_pkg::MODE_UNUSED, 8'hFF);
        run_frame(4, 4, 1);
        wait_idle();
        run_frame(4, 4, 2);
        wait_idle();

        // random coefficients and sizes, with one long receiver hold
        for (int f = 0; f < 2; f++) begin
            write_reg(cnv_pkg::REG_WIDTH, 11'($urandom_range(4, 6)));
            write_reg(cnv_pkg::REG_HEIGHT, 11'($urandom_range(4, 5)));
            for (int i = 0; i < 10; i++)
                send_coef($urandom_range(0, 48), 16'($urandom_range(0, 1200)) - 16'sd300);
            if (f == 0) hold_rx = 1;
            if (f == 1) calm = 1;
            run_frame(sb.width_reg, sb.height_reg, 0);
            wait_idle();
        end

        $display("ran %0d small frames with saturating and random kernels, %0d results checked",
                 n_frames, sb.n_seen);
        if (sb.n_bad == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.n_bad, sb.pending.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/cnv_pkg.sv
design/cnv_lb_ram.sv
design/cnv_mac.sv
design/cnv_ofifo.sv
design/image_filter_7x7_zero_padded.sv
tb/image_filter_7x7_zero_padded_tb.sv
